// ----- rtl/assert_macros.svh -----
//------------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers that compile to nothing under synthesis.
//------------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ----- rtl/pbu_pkg.sv -----
//------------------------------------------------------------------------------
// pbu_pkg
// Shared types and codes of the pixel blend unit.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

package pbu_pkg;

    localparam logic [2:0] MODE_MULTIPLY = 3'd0;
    localparam logic [2:0] MODE_SUBTRACT = 3'd1;
    localparam logic [2:0] MODE_OVERLAY  = 3'd2;
    localparam logic [2:0] MODE_SCREEN   = 3'd3;
    localparam logic [2:0] MODE_ADD_CH   = 3'd4;
    localparam logic [2:0] MODE_SCALE_CH = 3'd5;
    localparam logic [2:0] MODE_ONLY_CH  = 3'd6;

    localparam logic [1:0] CH_BLUE  = 2'd0;
    localparam logic [1:0] CH_GREEN = 2'd1;
    localparam logic [1:0] CH_RED   = 2'd2;

    localparam logic [1:0] REG_BLEND_MODE     = 2'd0;
    localparam logic [1:0] REG_CHANNEL_SELECT = 2'd1;
    localparam logic [1:0] REG_CHANNEL_AMOUNT = 2'd2;

    localparam int         ADDR_W = 4;

    typedef struct packed {
        logic [2:0] blend_mode;
        logic [1:0] channel_select;
        logic [7:0] channel_amount;
    } t_cfg;

endpackage

// ----- rtl/pbu_regs.sv -----
//------------------------------------------------------------------------------
// pbu_regs
// Configuration register bank behind an APB-style port.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

module pbu_regs (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [pbu_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    output pbu_pkg::t_cfg              o_cfg
);
    import pbu_pkg::*;

    t_cfg       r_cfg;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.blend_mode     <= MODE_MULTIPLY;
            r_cfg.channel_select <= CH_RED;
            r_cfg.channel_amount <= 8'd0;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_BLEND_MODE:     r_cfg.blend_mode     <= pwdata[2:0];
                REG_CHANNEL_SELECT: r_cfg.channel_select <= pwdata[1:0];
                REG_CHANNEL_AMOUNT: r_cfg.channel_amount <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_BLEND_MODE:     prdata = {29'd0, r_cfg.blend_mode};
            REG_CHANNEL_SELECT: prdata = {30'd0, r_cfg.channel_select};
            REG_CHANNEL_AMOUNT: prdata = {24'd0, r_cfg.channel_amount};
            default:            prdata = 32'd0;
        endcase
    end

endmodule

// ----- rtl/pbu_channel.sv -----
//------------------------------------------------------------------------------
// pbu_channel
// Two-image blend of one 8-bit channel: multiply, subtract, overlay, screen.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

module pbu_channel (
    input  logic [2:0] i_mode,
    input  logic [7:0] i_top,
    input  logic [7:0] i_bottom,
    output logic [7:0] o_result
);
    import pbu_pkg::*;

    logic        is_overlay;
    logic        inv;
    logic [7:0]  op_a;
    logic [7:0]  op_b;
    logic [15:0] prod;
    logic [16:0] num;
    logic [17:0] biased;
    logic [9:0]  q_est;
    logic [9:0]  rem;
    logic [9:0]  quot;
    logic [7:0]  rounded;
    logic [7:0]  blended;

    // Screen and the upper half of overlay work on the complemented operands.
    assign is_overlay = (i_mode == MODE_OVERLAY);
    assign inv        = (i_mode == MODE_SCREEN) || (is_overlay && i_bottom[7]);
    assign op_a       = inv ? ~i_top : i_top;
    assign op_b       = inv ? ~i_bottom : i_bottom;
    assign prod       = op_a * op_b;
    assign num        = is_overlay ? {prod, 1'b0} : {1'b0, prod};

    // Rounded division by 255: estimate by a shift, then correct by the remainder.
    assign biased = {1'b0, num} + 18'd127;
    assign q_est  = biased[17:8];
    assign rem    = {2'b00, biased[7:0]} + q_est;

    always_comb begin
        if (rem >= 10'd510) begin
            quot = q_est + 10'd2;
        end else if (rem >= 10'd255) begin
            quot = q_est + 10'd1;
        end else begin
            quot = q_est;
        end
    end

    assign rounded = quot[7:0];
    assign blended = inv ? ~rounded : rounded;

    always_comb begin
        case (i_mode)
            MODE_MULTIPLY, MODE_OVERLAY, MODE_SCREEN: o_result = blended;
            MODE_SUBTRACT: o_result = (i_top > i_bottom) ? (i_top - i_bottom) : 8'd0;
            default:       o_result = i_top;
        endcase
    end

endmodule

// ----- rtl/pixel_blend_unit.sv -----
//------------------------------------------------------------------------------
// pixel_blend_unit
// Blends a top and a bottom pixel of three 8-bit channels into one pixel.
//------------------------------------------------------------------------------
// Usage: a request on the input channel carries one top and one bottom pixel
// and is taken at a clock edge with i_valid high and o_stall low. Each request
// gives exactly one blended pixel on the output channel, which is taken at an
// edge with o_valid high and i_stall low.
// The pipeline is an input register and a result register with the blend
// logic between them; a taken pixel passes from the input register through
// the blend logic into the result register, which presents it on the output.
// One pixel is taken in every cycle while the receiver does not stall.
// When the receiver stalls, the held result stays put and one more request is
// still taken into the input register; o_stall rises only when both stages
// are full.
// The blend mode, channel select and channel amount are set through the APB
// port, at byte addresses 0, 4 and 8, while no request is in flight; the user
// must keep to this, as the block does not enforce it. After the synchronous
// reset both stages are empty; mode multiply, red channel, amount zero.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pixel_blend_unit (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [pbu_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic [7:0]                 i_top_blue,
    input  logic [7:0]                 i_top_green,
    input  logic [7:0]                 i_top_red,
    input  logic [7:0]                 i_bottom_blue,
    input  logic [7:0]                 i_bottom_green,
    input  logic [7:0]                 i_bottom_red,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic [7:0]                 o_out_blue,
    output logic [7:0]                 o_out_green,
    output logic [7:0]                 o_out_red
);
    import pbu_pkg::*;

    t_cfg        cfg;
    logic        r_s1_valid;
    logic        r_out_valid;
    logic [7:0]  r_top [3];
    logic [7:0]  r_bot [3];
    logic [7:0]  r_res [3];
    logic [7:0]  blend [3];
    logic [7:0]  n_res [3];
    logic        s1_adv;
    logic        in_acc;
    logic        ch_ok;
    logic [7:0]  top_sel;
    logic [8:0]  add_sum;
    logic [15:0] scale_prod;
    logic [7:0]  ch_val;

    pbu_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    for (genvar k = 0; k < 3; k++) begin : g_lane
        pbu_channel u_channel (
            .i_mode   (cfg.blend_mode),
            .i_top    (r_top[k]),
            .i_bottom (r_bot[k]),
            .o_result (blend[k])
        );
    end

    assign s1_adv  = !r_out_valid || !i_stall;
    assign o_stall = r_s1_valid && !s1_adv;
    assign in_acc  = i_valid && !o_stall;

    always_comb begin
        ch_ok = 1'b1;
        case (cfg.channel_select)
            CH_BLUE:  top_sel = r_top[0];
            CH_GREEN: top_sel = r_top[1];
            CH_RED:   top_sel = r_top[2];
            default: begin
                top_sel = 8'd0;
                ch_ok   = 1'b0;
            end
        endcase
    end

    assign add_sum    = {1'b0, top_sel} + {1'b0, cfg.channel_amount};
    assign scale_prod = top_sel * cfg.channel_amount;

    always_comb begin
        case (cfg.blend_mode)
            MODE_ADD_CH:   ch_val = add_sum[8] ? 8'hFF : add_sum[7:0];
            MODE_SCALE_CH: ch_val = (scale_prod[15:8] != 8'd0) ? 8'hFF : scale_prod[7:0];
            default:       ch_val = top_sel;
        endcase
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_res[k] = blend[k];
        end
        case (cfg.blend_mode)
            MODE_ADD_CH, MODE_SCALE_CH: begin
                if (ch_ok) begin
                    n_res[cfg.channel_select] = ch_val;
                end
            end
            MODE_ONLY_CH: begin
                if (ch_ok) begin
                    for (int k = 0; k < 3; k++) begin
                        n_res[k] = top_sel;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (!o_stall) begin
                r_s1_valid <= i_valid;
            end
            if (s1_adv) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_top[0] <= i_top_blue;
            r_top[1] <= i_top_green;
            r_top[2] <= i_top_red;
            r_bot[0] <= i_bottom_blue;
            r_bot[1] <= i_bottom_green;
            r_bot[2] <= i_bottom_red;
        end
        if (s1_adv && r_s1_valid) begin
            r_res <= n_res;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_out_blue  = r_res[0];
    assign o_out_green = r_res[1];
    assign o_out_red   = r_res[2];

    `ASSERT_NEXT(a_accept_fills, i_clk, i_rst_n, in_acc, r_s1_valid)
    `ASSERT_NEXT(a_stage_moves, i_clk, i_rst_n, r_s1_valid && s1_adv, o_valid)
    `ASSERT_NEXT(a_drain_empties, i_clk, i_rst_n, o_valid && !i_stall && !r_s1_valid, !o_valid)
    `ASSERT_IMPLY(a_stall_full, i_clk, i_rst_n, o_stall, r_s1_valid && o_valid && i_stall)

endmodule
